// ===== design/sca_pkg.sv =====
// ----------------------------------------------------------------------------
// sca_pkg: shared constants and types
// Sizes, codes and the sequencer state encoding of the slab allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package sca_pkg;
    localparam int NUM_CHUNKS  = 8;
    localparam int CHUNK_UNITS = 1024;
    localparam int NUM_CLASSES = 12;
    localparam int UNIT_BYTES  = 16;

    localparam int CW  = $clog2(NUM_CHUNKS);
    localparam int LW  = $clog2(NUM_CHUNKS + 1);
    localparam int OW  = $clog2(CHUNK_UNITS);
    localparam int UW  = $clog2(CHUNK_UNITS + 1);
    localparam int KW  = $clog2(NUM_CLASSES);
    localparam int FAW = $clog2(NUM_CHUNKS * CHUNK_UNITS);

    localparam logic [LW-1:0] NONE_CHUNK = LW'(NUM_CHUNKS);
    localparam logic [UW-1:0] NONE_UNIT  = UW'(CHUNK_UNITS);
    localparam logic [15:0]   MAX_BYTES  = 16'(NUM_CLASSES * UNIT_BYTES);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_GEN  = 2'd1;
    localparam logic [1:0] ST_OOM  = 2'd2;
    localparam logic [1:0] ST_NULL = 2'd3;

    localparam logic CMD_TAKE = 1'b0;
    localparam logic CMD_GIVE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_WALK, S_POP, S_GIVE, S_DONE
    } state_t;
endpackage
`default_nettype wire

// ===== design/sca_ram.sv =====
// ----------------------------------------------------------------------------
// sca_ram: generic single-port RAM
// One write and one read at the same address per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module sca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== design/size_class_slab_allocator_top.sv =====
// ----------------------------------------------------------------------------
// size_class_slab_allocator_top: size-class slab allocator
// Serves takes and gives of small nodes from a pool of chunk slots.
// ----------------------------------------------------------------------------
// One transaction on the input channel (in_valid/in_stall) carries a take or
// a give; each yields exactly one result transaction on the output channel
// (out_valid/out_stall). The block works on one transaction at a time:
// in_stall stays high from acceptance until the result has been taken.
// A take rounds the size up to 16-byte units and walks its class's chunk
// list one chunk per cycle in a small sequencer. A take that bumps into
// unused space or claims a new slot goes from the walk state straight to
// the result; one that pops a chunk's free list passes through a pop
// state first (the free-link RAM read). A give passes through the give
// state, a rejected take through the walk state. A new transaction is
// taken the cycle after the result leaves. Failing takes claim the
// lowest idle slot with a priority encode. When the receiver stalls, the
// result register holds its value and no new transaction is accepted.
// Reset clears the class heads, next-chunk links, active flags and counts
// at once; the free-link RAM needs no clearing, since an entry is only
// read after a give wrote it.
// ----------------------------------------------------------------------------
`default_nettype none
module size_class_slab_allocator_top
    import sca_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [15:0] size_bytes,
    input  wire logic        handle_present,
    input  wire logic [2:0]  handle_chunk,
    input  wire logic [9:0]  handle_offset,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [2:0]       out_chunk,
    output logic [9:0]       out_offset,
    output logic             chunk_released,
    output logic [13:0]      live_total,
    output logic [3:0]       chunks_in_use
);
    state_t state_reg, state_next;

    logic [LW-1:0] class_head_reg [NUM_CLASSES];
    logic [LW-1:0] chunk_next_reg [NUM_CHUNKS];
    logic [LW-1:0] chunk_prev_reg [NUM_CHUNKS];
    logic          chunk_active_reg [NUM_CHUNKS];
    logic [KW-1:0] chunk_class_reg [NUM_CHUNKS];
    logic [UW-1:0] free_head_reg [NUM_CHUNKS];
    logic [UW-1:0] bump_reg [NUM_CHUNKS];
    logic [UW-1:0] chunk_live_reg [NUM_CHUNKS];
    logic [13:0]   live_count_reg;
    logic [LW-1:0] active_cnt_reg;

    // Latched transaction and walk state.
    logic          cmd_reg;
    logic          hp_reg;
    logic [2:0]    hc_reg;
    logic [9:0]    ho_reg;
    logic [KW-1:0] ci_reg;
    logic [UW-1:0] k_reg;
    logic [LW-1:0] cur_reg;
    logic [LW-1:0] steps_reg;

    logic [1:0]    status_reg;
    logic [CW-1:0] oc_reg;
    logic [OW-1:0] oo_reg;
    logic          rel_reg;

    // Free-link RAM port.
    logic           ram_we;
    logic [FAW-1:0] ram_addr;
    logic [UW-1:0]  ram_wdata, ram_rdata;

    sca_ram #(.WIDTH(UW), .DEPTH(NUM_CHUNKS * CHUNK_UNITS)) u_link (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    logic          accept;
    logic [CW-1:0] cur_c;
    logic [CW-1:0] give_c;
    logic [16:0]   size_up;
    logic [UW:0]   bump_sum;
    logic          have_idle;
    logic [CW-1:0] idle_slot;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign cur_c    = cur_reg[CW-1:0];
    assign give_c   = CW'(hc_reg);
    assign size_up  = {1'b0, size_bytes} + 17'(UNIT_BYTES - 1);
    assign bump_sum = {1'b0, bump_reg[cur_c]} + {1'b0, k_reg};

    always_comb
    begin
        have_idle = 1'b0;
        idle_slot = '0;
        for (int i = NUM_CHUNKS - 1; i >= 0; i--)
        begin
            if (!chunk_active_reg[i])
            begin
                have_idle = 1'b1;
                idle_slot = CW'(i);
            end
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = {cur_c, free_head_reg[cur_c][OW-1:0]};
        ram_wdata = free_head_reg[give_c];
        if (state_reg == S_GIVE)
        begin
            ram_addr = {give_c, ho_reg[OW-1:0]};
            ram_we   = hp_reg && ({1'b0, hc_reg} < 4'(NUM_CHUNKS))
                       && chunk_active_reg[give_c] && (32'(ho_reg) < CHUNK_UNITS);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = (cmd == CMD_GIVE) ? S_GIVE : S_WALK;
            S_WALK:
            begin
                if (cur_reg < NONE_CHUNK && steps_reg < NONE_CHUNK
                    && free_head_reg[cur_c] < NONE_UNIT)
                    state_next = S_POP;
                else if (!(cur_reg < NONE_CHUNK && steps_reg < NONE_CHUNK
                           && bump_sum <= (UW+1)'(CHUNK_UNITS))
                         && (cur_reg < NONE_CHUNK && steps_reg < NONE_CHUNK))
                    state_next = S_WALK;
                else
                    state_next = S_DONE;
            end
            S_POP:  state_next = S_DONE;
            S_GIVE: state_next = S_DONE;
            S_DONE: if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            live_count_reg <= '0;
            active_cnt_reg <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) class_head_reg[i] <= NONE_CHUNK;
            for (int i = 0; i < NUM_CHUNKS; i++)
            begin
                chunk_next_reg[i]   <= NONE_CHUNK;
                chunk_active_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg    <= cmd;
                        hp_reg     <= handle_present;
                        hc_reg     <= handle_chunk;
                        ho_reg     <= handle_offset;
                        ci_reg     <= KW'(size_up[16:4] - 13'd1);
                        k_reg      <= UW'(size_up[16:4]);
                        rel_reg    <= 1'b0;
                        oc_reg     <= '0;
                        oo_reg     <= '0;
                        if (cmd == CMD_TAKE && (size_bytes == 16'd0 || size_bytes > MAX_BYTES))
                        begin
                            cur_reg    <= NONE_CHUNK;
                            steps_reg  <= NONE_CHUNK;
                            status_reg <= ST_GEN;
                        end
                        else if (cmd == CMD_TAKE)
                        begin
                            cur_reg    <= class_head_reg[KW'(size_up[16:4] - 13'd1)];
                            steps_reg  <= '0;
                            status_reg <= ST_OK;
                        end
                        else
                        begin
                            cur_reg    <= NONE_CHUNK;
                            steps_reg  <= '0;
                            status_reg <= ST_OK;
                        end
                    end
                end
                S_WALK:
                begin
                    if (status_reg == ST_GEN)
                    begin
                        // Rejected take: nothing to do.
                    end
                    else if (cur_reg < NONE_CHUNK && steps_reg < NONE_CHUNK)
                    begin
                        if (free_head_reg[cur_c] < NONE_UNIT)
                        begin
                            oc_reg <= cur_c;
                            oo_reg <= free_head_reg[cur_c][OW-1:0];
                        end
                        else if (bump_sum <= (UW+1)'(CHUNK_UNITS))
                        begin
                            oc_reg              <= cur_c;
                            oo_reg              <= bump_reg[cur_c][OW-1:0];
                            bump_reg[cur_c]     <= UW'(bump_sum);
                            chunk_live_reg[cur_c] <= chunk_live_reg[cur_c] + 1'b1;
                            live_count_reg      <= live_count_reg + 14'd1;
                        end
                        else
                        begin
                            cur_reg   <= chunk_next_reg[cur_c];
                            steps_reg <= steps_reg + 1'b1;
                        end
                    end
                    else if (!have_idle)
                    begin
                        status_reg <= ST_OOM;
                    end
                    else
                    begin
                        chunk_active_reg[idle_slot] <= 1'b1;
                        chunk_class_reg[idle_slot]  <= ci_reg;
                        chunk_next_reg[idle_slot]   <= class_head_reg[ci_reg];
                        chunk_prev_reg[idle_slot]   <= NONE_CHUNK;
                        if (class_head_reg[ci_reg] < NONE_CHUNK)
                            chunk_prev_reg[class_head_reg[ci_reg][CW-1:0]] <= LW'(idle_slot);
                        class_head_reg[ci_reg]      <= LW'(idle_slot);
                        free_head_reg[idle_slot]    <= NONE_UNIT;
                        bump_reg[idle_slot]         <= k_reg;
                        chunk_live_reg[idle_slot]   <= UW'(1);
                        live_count_reg              <= live_count_reg + 14'd1;
                        active_cnt_reg              <= active_cnt_reg + 1'b1;
                        oc_reg                      <= idle_slot;
                        oo_reg                      <= '0;
                    end
                end
                S_POP:
                begin
                    free_head_reg[cur_c]  <= ram_rdata;
                    chunk_live_reg[cur_c] <= chunk_live_reg[cur_c] + 1'b1;
                    live_count_reg        <= live_count_reg + 14'd1;
                end
                S_GIVE:
                begin
                    if (!hp_reg)
                        status_reg <= ST_NULL;
                    else if (!ram_we)
                        status_reg <= ST_GEN;
                    else
                    begin
                        free_head_reg[give_c] <= UW'(ho_reg);
                        if (chunk_live_reg[give_c] != '0)
                            chunk_live_reg[give_c] <= chunk_live_reg[give_c] - 1'b1;
                        if (live_count_reg != '0)
                            live_count_reg <= live_count_reg - 14'd1;
                        if (chunk_live_reg[give_c] <= UW'(1))
                        begin
                            // Chunk emptied: unlink it from its class list.
                            rel_reg <= 1'b1;
                            if (chunk_prev_reg[give_c] < NONE_CHUNK)
                                chunk_next_reg[chunk_prev_reg[give_c][CW-1:0]]
                                    <= chunk_next_reg[give_c];
                            else if (32'(chunk_class_reg[give_c]) < NUM_CLASSES)
                                class_head_reg[chunk_class_reg[give_c]]
                                    <= chunk_next_reg[give_c];
                            if (chunk_next_reg[give_c] < NONE_CHUNK)
                                chunk_prev_reg[chunk_next_reg[give_c][CW-1:0]]
                                    <= chunk_prev_reg[give_c];
                            chunk_active_reg[give_c] <= 1'b0;
                            chunk_next_reg[give_c]   <= NONE_CHUNK;
                            active_cnt_reg           <= active_cnt_reg - 1'b1;
                        end
                    end
                end
                S_DONE: ;
                default: ;
            endcase
        end
    end

    assign out_valid      = (state_reg == S_DONE);
    assign status         = status_reg;
    assign out_chunk      = 3'(oc_reg);
    assign out_offset     = 10'(oo_reg);
    assign chunk_released = rel_reg;
    assign live_total     = live_count_reg;
    assign chunks_in_use  = 4'(active_cnt_reg);

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("result shown while idle");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("result changed under stall");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        active_cnt_reg <= NONE_CHUNK) else $error("active count overflow");
    a_rel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && chunk_released |-> status == ST_OK && cmd_reg == CMD_GIVE)
        else $error("release on a non-give");
endmodule
`default_nettype wire
